// ===== design/dcpec_pkg.sv =====
// Shared types, constants and the CRC table function of the daisy-chain PEC frame checker.
package dcpec_pkg;

    localparam logic [15:0] PEC_SEED = 16'h0010;
    localparam logic [15:0] PEC_POLY = 16'h4599;
    localparam int unsigned OUT_WORDS = 3;
    localparam int unsigned OUT_BYTES = 2 * OUT_WORDS;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } dcpec_in_t;

    typedef struct packed {
        logic [3:0]  device_number;
        logic [15:0] word_first;
        logic [15:0] word_second;
        logic [15:0] word_third;
        logic        pec_ok;
        logic        last_device;
    } dcpec_out_t;

    function automatic logic [15:0] pec_table(input logic [7:0] idx);
        logic [15:0] r;
        r = {1'b0, idx, 7'b0};
        for (int b = 0; b < 8; b++)
        begin
            if (r[14])
                r = {r[14:0], 1'b0} ^ PEC_POLY;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== design/dcpec_crc_step.sv =====
// One byte of the 15-bit packet error code update, as a table XOR network.
module dcpec_crc_step
    import dcpec_pkg::*;
(
    input  logic [15:0] crc,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    logic [7:0] addr;

    assign addr    = crc[14:7] ^ data;
    assign crc_out = {crc[7:0], 8'b0} ^ pec_table(addr);

endmodule

// ===== design/daisy_chain_pec_frame_checker.sv =====
// Top level of the daisy-chain PEC frame checker: input register, frame logic, result register.
// Each accepted beat is one received byte, held in the input register and passed to the
// result register; a new byte is accepted every cycle while the result register can drain.
// Every FRAME_BYTES bytes close a device frame and yield one result beat carrying the three
// little-endian data words, the packet error code check and the last-device mark. A byte
// flagged as frame start restarts the frame and device counters, dropping any partial frame.
// The device count must be written through cfg_wr_en and cfg_wr_data only while idle, which
// the block does not enforce; zero acts as one and values above MAX_DEVICES as MAX_DEVICES.
module daisy_chain_pec_frame_checker
    import dcpec_pkg::*;
#(
    parameter int unsigned MAX_DEVICES = 16,
    parameter int unsigned FRAME_BYTES = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dcpec_in_t  in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output dcpec_out_t out_data,
    input  logic       cfg_wr_en,
    input  logic [4:0] cfg_wr_data
);

    localparam int unsigned DATA_BYTES  = FRAME_BYTES - 2;
    localparam int unsigned STORE_DEPTH = FRAME_BYTES - 1;
    localparam int unsigned BP_W        = $clog2(FRAME_BYTES);
    localparam int unsigned DEV_W       = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

    logic             in_valid_reg;
    dcpec_in_t        in_data_reg;
    logic             out_valid_reg;
    dcpec_out_t       out_data_reg;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [BP_W-1:0]  byte_pos_reg;
    logic [BP_W-1:0]  byte_pos_next;
    logic [DEV_W-1:0] dev_pos_reg;
    logic [DEV_W-1:0] dev_pos_next;
    logic [4:0]       dev_count_reg;
    logic [7:0]       store_reg [STORE_DEPTH];

    logic [15:0]      crc0;
    logic [15:0]      crc_upd;
    logic [BP_W-1:0]  pos0;
    logic [DEV_W-1:0] dev0;
    logic             is_end;
    logic             advance;
    logic [6:0]       eff_count;
    logic [6:0]       dev_ext;
    logic             last;
    logic [7:0]       data_bytes [OUT_BYTES];
    dcpec_out_t       result;

    assign crc0 = in_data_reg.frame_start ? PEC_SEED : crc_reg;
    assign pos0 = in_data_reg.frame_start ? '0 : byte_pos_reg;
    assign dev0 = in_data_reg.frame_start ? '0 : dev_pos_reg;

    assign is_end  = (pos0 == BP_W'(FRAME_BYTES - 1));
    assign advance = in_valid_reg && (!is_end || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    dcpec_crc_step u_crc_step (
        .crc     (crc0),
        .data    (in_data_reg.rx_byte),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        if (dev_count_reg == 5'd0)
            eff_count = 7'd1;
        else if (7'(dev_count_reg) > 7'(MAX_DEVICES))
            eff_count = 7'(MAX_DEVICES);
        else
            eff_count = 7'(dev_count_reg);
    end

    assign dev_ext = 7'(dev0);
    assign last    = (dev_ext + 7'd1) >= eff_count;

    for (genvar k = 0; k < OUT_BYTES; k++)
    begin : g_data
        if (k < DATA_BYTES)
        begin : g_stored
            assign data_bytes[k] = store_reg[k];
        end
        else
        begin : g_absent
            assign data_bytes[k] = 8'd0;
        end
    end

    always_comb
    begin
        result.device_number = dev_ext[3:0];
        result.word_first    = {data_bytes[1], data_bytes[0]};
        result.word_second   = {data_bytes[3], data_bytes[2]};
        result.word_third    = {data_bytes[5], data_bytes[4]};
        result.pec_ok        = ({crc0[14:0], 1'b0} ==
                                {store_reg[FRAME_BYTES - 2], in_data_reg.rx_byte});
        result.last_device   = last;
    end

    always_comb
    begin
        if (is_end)
        begin
            crc_next      = PEC_SEED;
            byte_pos_next = '0;
            dev_pos_next  = last ? '0 : dev0 + DEV_W'(1);
        end
        else
        begin
            crc_next      = (pos0 < BP_W'(DATA_BYTES)) ? crc_upd : crc0;
            byte_pos_next = pos0 + BP_W'(1);
            dev_pos_next  = dev0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= PEC_SEED;
            byte_pos_reg  <= '0;
            dev_pos_reg   <= '0;
            dev_count_reg <= 5'd1;
        end
        else
        begin
            if (in_valid && in_ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance && is_end)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                crc_reg      <= crc_next;
                byte_pos_reg <= byte_pos_next;
                dev_pos_reg  <= dev_pos_next;
            end

            if (cfg_wr_en)
                dev_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_data;
        if (advance && is_end)
            out_data_reg <= result;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (advance && !is_end && (pos0 == BP_W'(i)))
                store_reg[i] <= in_data_reg.rx_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_byte_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_pos_reg <= BP_W'(FRAME_BYTES - 1))
        else $error("byte position beyond frame length");

    a_dev_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        7'(dev_pos_reg) < 7'(MAX_DEVICES))
        else $error("device position beyond device limit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && is_end && out_valid_reg && !out_ready) |-> !advance)
        else $error("result register overwritten while a beat waits");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_end) |=> out_valid_reg)
        else $error("frame end did not load a result beat");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_end && last) |=> (dev_pos_reg == '0) && (byte_pos_reg == '0))
        else $error("counters did not wrap after the last device");

endmodule

// ===== bench/daisy_chain_pec_frame_checker_test.sv =====
// Self-checking testbench for the daisy-chain PEC frame checker.
module daisy_chain_pec_frame_checker_test;
    import dcpec_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CHAIN_MAX = 16;
    localparam int unsigned FRAME_LEN = 8;
    localparam int unsigned PAYLOAD_LEN = FRAME_LEN - 2;
    localparam int unsigned TOTAL_ITEMS = 1250;
    localparam int unsigned SETTLE_CYCLES = 4;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    dcpec_in_t  in_data;
    logic       out_valid;
    logic       out_ready;
    dcpec_out_t out_data;
    logic       cfg_wr_en;
    logic [4:0] cfg_wr_data;

    logic [15:0] chk_crc;
    int unsigned chk_pos;
    int unsigned chk_dev;
    logic [7:0]  chk_store [FRAME_LEN - 1];
    logic [4:0]  chk_count;

    dcpec_out_t  pending_frames [$];
    int unsigned mismatches;
    int unsigned bytes_sent;
    bit          idle_tx;
    bit          idle_rx;

    daisy_chain_pec_frame_checker uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [15:0] crc_after_byte(input logic [15:0] rem, input logic [7:0] b);
        logic [15:0] t;
        t = {1'b0, rem[14:7] ^ b, 7'b0};
        for (int k = 0; k < 8; k++)
        begin
            if (t[14])
                t = {t[14:0], 1'b0} ^ PEC_POLY;
            else
                t = {t[14:0], 1'b0};
        end
        return {rem[7:0], 8'h00} ^ t;
    endfunction

    function automatic logic [5:0][7:0] random_payload();
        logic [5:0][7:0] p;
        for (int k = 0; k < PAYLOAD_LEN; k++)
        begin
            case ($urandom_range(0, 7))
                0: p[k] = 8'h00;
                1: p[k] = 8'hFF;
                default: p[k] = 8'($urandom);
            endcase
        end
        return p;
    endfunction

    task automatic track_byte(input logic [7:0] b, input logic fs);
        dcpec_out_t  want;
        logic [15:0] computed;
        logic [15:0] received;
        int unsigned eff;
        logic        last;
        if (fs)
        begin
            chk_crc = PEC_SEED;
            chk_pos = 0;
            chk_dev = 0;
        end
        if (chk_pos < FRAME_LEN - 1)
        begin
            if (chk_pos < PAYLOAD_LEN)
                chk_crc = crc_after_byte(chk_crc, b);
            chk_store[chk_pos] = b;
            chk_pos++;
        end
        else
        begin
            computed = {chk_crc[14:0], 1'b0};
            received = {chk_store[FRAME_LEN - 2], b};
            eff = chk_count;
            if (eff < 1)
                eff = 1;
            if (eff > CHAIN_MAX)
                eff = CHAIN_MAX;
            last = (chk_dev + 1 >= eff);
            want.device_number = 4'(chk_dev);
            want.word_first    = {chk_store[1], chk_store[0]};
            want.word_second   = {chk_store[3], chk_store[2]};
            want.word_third    = {chk_store[5], chk_store[4]};
            want.pec_ok        = (computed == received);
            want.last_device   = last;
            pending_frames.push_back(want);
            chk_crc = PEC_SEED;
            chk_pos = 0;
            chk_dev = last ? 0 : chk_dev + 1;
        end
    endtask

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        mismatches++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fs);
        int unsigned gap;
        gap = idle_tx ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{rx_byte: b, frame_start: fs};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_byte(b, fs);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [5:0][7:0] payload, input logic fs,
                              input logic [15:0] flip);
        logic [15:0] rem;
        logic [15:0] code;
        rem = PEC_SEED;
        for (int k = 0; k < PAYLOAD_LEN; k++)
            rem = crc_after_byte(rem, payload[k]);
        code = {rem[14:0], 1'b0} ^ flip;
        for (int k = 0; k < PAYLOAD_LEN; k++)
            send_byte(payload[k], fs && k == 0);
        send_byte(code[15:8], 1'b0);
        send_byte(code[7:0], 1'b0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_device_count(input logic [4:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        chk_count = value;
    endtask

    task automatic send_read(input int unsigned frames);
        repeat (frames)
            send_frame(random_payload(), chk_dev == 0, 16'h0000);
    endtask

    task automatic test_directed_frames();
        send_frame({6{8'h00}}, 1'b1, 16'h0000);
        send_frame({6{8'hFF}}, 1'b0, 16'hFFFF);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_frame(random_payload(), 1'b1, 16'h0000);
    endtask

    task automatic test_device_counts();
        logic [4:0] counts [5] = '{5'd0, 5'd17, 5'd31, 5'd16, 5'd1};
        int unsigned eff;
        foreach (counts[i])
        begin
            drain();
            write_device_count(counts[i]);
            eff = (counts[i] == 0) ? 1 : (counts[i] > CHAIN_MAX) ? CHAIN_MAX : counts[i];
            send_frame(random_payload(), 1'b1, 16'h0000);
            send_read(eff);
        end
    endtask

    task automatic test_count_lowered();
        drain();
        write_device_count(5'd12);
        send_frame(random_payload(), 1'b1, 16'h0000);
        send_read(6);
        drain();
        write_device_count(5'd4);
        send_read(3);
    endtask

    task automatic test_random_traffic();
        int unsigned frames;
        int unsigned kind;
        logic [15:0] flip;
        logic        fs;
        while (bytes_sent < TOTAL_ITEMS)
        begin
            drain();
            case ($urandom_range(0, 7))
                0: write_device_count(5'd0);
                1: write_device_count(5'd1);
                2: write_device_count(5'd16);
                3: write_device_count(5'($urandom_range(17, 31)));
                default: write_device_count(5'($urandom_range(2, 8)));
            endcase
            idle_tx = ($urandom_range(0, 3) != 0);
            idle_rx = ($urandom_range(0, 3) != 0);
            frames = $urandom_range(1, 24);
            repeat (frames)
            begin
                kind = $urandom_range(0, 19);
                if (kind < 2)
                begin
                    repeat ($urandom_range(1, 7))
                        send_byte(8'($urandom), $urandom_range(0, 5) == 0);
                end
                if (kind < 5)
                    flip = 16'h0001 << $urandom_range(0, 15);
                else if (kind == 5)
                    flip = 16'($urandom);
                else
                    flip = 16'h0000;
                if (chk_pos != 0)
                    fs = ($urandom_range(0, 3) != 0);
                else
                    fs = (chk_dev == 0) && ($urandom_range(0, 3) != 0);
                send_frame(random_payload(), fs, flip);
            end
        end
    endtask

    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            dcpec_out_t got;
            dcpec_out_t want;
            int unsigned gap;
            gap = idle_rx ? $urandom_range(0, 9) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            got = out_data;
            if (pending_frames.size() == 0)
            begin
                report_mismatch("unexpected beat", got.word_first, 16'h0000);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (got.device_number !== want.device_number)
                    report_mismatch("device_number", 16'(got.device_number),
                                    16'(want.device_number));
                if (got.word_first !== want.word_first)
                    report_mismatch("word_first", got.word_first, want.word_first);
                if (got.word_second !== want.word_second)
                    report_mismatch("word_second", got.word_second, want.word_second);
                if (got.word_third !== want.word_third)
                    report_mismatch("word_third", got.word_third, want.word_third);
                if (got.pec_ok !== want.pec_ok)
                    report_mismatch("pec_ok", 16'(got.pec_ok), 16'(want.pec_ok));
                if (got.last_device !== want.last_device)
                    report_mismatch("last_device", 16'(got.last_device),
                                    16'(want.last_device));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("daisy_chain_pec_frame_checker_test: done, errors");
        $finish;
    end

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        mismatches = 0;
        bytes_sent = 0;
        idle_tx = 1'b1;
        idle_rx = 1'b1;
        chk_crc = PEC_SEED;
        chk_pos = 0;
        chk_dev = 0;
        chk_count = 5'd1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_device_counts();
        test_count_lowered();
        test_random_traffic();
        drain();
        if (mismatches == 0)
            $display("daisy_chain_pec_frame_checker_test: done, clean");
        else
            $display("daisy_chain_pec_frame_checker_test: done, errors");
        $finish;
    end

endmodule

// ===== daisy_chain_pec_frame_checker.f =====
design/dcpec_pkg.sv
design/dcpec_crc_step.sv
design/daisy_chain_pec_frame_checker.sv
bench/daisy_chain_pec_frame_checker_test.sv
